// ===== design/block_ring_sample_buffer_assert.svh =====
// assertion macros for the block ring sample buffer
// expects clk_i and rst_ni in the scope of the including module
`ifndef BLOCK_RING_SAMPLE_BUFFER_ASSERT_SVH
`define BLOCK_RING_SAMPLE_BUFFER_ASSERT_SVH

// same-cycle implication
`define BRSB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRSB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/brsb_pkg.sv =====
// shared constants and types of the block ring sample buffer
// no dependencies
`default_nettype none

package brsb_pkg;

  localparam int BLOCKS   = 4;
  localparam int LINES    = 8;
  localparam int CHANNELS = 8;

  localparam int KIND_W   = 3;
  localparam int CHAN_W   = 3;
  localparam int RLINE_W  = 3;
  localparam int RFIELD_W = 4;
  localparam int VALUE_W  = 32;
  localparam int SAMPLE_W = 16;

  localparam int ROWS      = BLOCKS * LINES;
  localparam int SMP_DEPTH = ROWS * CHANNELS;
  localparam int BLK_W     = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
  localparam int LINE_W    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SMP_W     = (SMP_DEPTH > 1) ? $clog2(SMP_DEPTH) : 1;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [KIND_W-1:0] {
    OP_SAMPLE  = 3'd0,
    OP_SYNC    = 3'd1,
    OP_TIME    = 3'd2,
    OP_ENDLINE = 3'd3,
    OP_QUERY   = 3'd4,
    OP_READ    = 3'd5,
    OP_RELEASE = 3'd6,
    OP_CLEAR   = 3'd7
  } op_e;

  localparam logic [RFIELD_W-1:0] FIELD_TIME = 4'd0;
  localparam logic [RFIELD_W-1:0] FIELD_SYNC = 4'd1;
  localparam logic [RFIELD_W-1:0] FIELD_SMP0 = 4'd2;

  typedef struct packed {
    logic capture;
    logic exec;
    op_e  op;
  } cmd_t;

  typedef struct packed {
    logic overrun;
  } status_t;

endpackage

`default_nettype wire

// ===== design/brsb_if.sv =====
// request and result channel interfaces of the block ring sample buffer
// depends on brsb_pkg
`default_nettype none

interface brsb_req_if;
  import brsb_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [CHAN_W-1:0]   channel;
  logic [RLINE_W-1:0]  read_line;
  logic [RFIELD_W-1:0] read_field;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, kind, channel, read_line, read_field, value, input ready);
  modport sink (input valid, kind, channel, read_line, read_field, value, output ready);
endinterface

interface brsb_rsp_if;
  import brsb_pkg::*;

  logic               valid;
  logic               ready;
  logic               accepted_ok;
  logic               block_ready;
  logic [VALUE_W-1:0] read_value;

  modport source (output valid, accepted_ok, block_ready, read_value, input ready);
  modport sink (input valid, accepted_ok, block_ready, read_value, output ready);
endinterface

`default_nettype wire

// ===== design/brsb_ctrl.sv =====
// controller of the block ring sample buffer: request handshake and sequencing
// depends on brsb_pkg and block_ring_sample_buffer_assert.svh
`default_nettype none

module brsb_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [brsb_pkg::KIND_W-1:0] kind_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output brsb_pkg::cmd_t                cmd_o,
  input  wire brsb_pkg::status_t        status_i
);
  import brsb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   capture;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign capture     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.capture = capture;
  assign cmd_o.exec    = (state_q == S_EXEC);
  assign cmd_o.op      = op_e'(kind_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (capture) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (state_q == S_EXEC) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`include "block_ring_sample_buffer_assert.svh"

  `BRSB_ASSERT_NEXT(a_exec_after_capture, capture, state_q == S_EXEC, "capture not followed by exec")
  `BRSB_ASSERT_NEXT(a_result_after_exec, state_q == S_EXEC, out_valid_q, "exec gave no result")
  `BRSB_ASSERT_NOW(a_overrun_in_exec, status_i.overrun, state_q == S_EXEC, "overrun outside exec")

endmodule

`default_nettype wire

// ===== design/brsb_dpath.sv =====
// datapath of the block ring sample buffer: line stores, heads, ready marks, result register
// depends on brsb_pkg and block_ring_sample_buffer_assert.svh
`default_nettype none

module brsb_dpath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire brsb_pkg::cmd_t                cmd_i,
  input  wire logic [brsb_pkg::CHAN_W-1:0]   channel_i,
  input  wire logic [brsb_pkg::RLINE_W-1:0]  read_line_i,
  input  wire logic [brsb_pkg::RFIELD_W-1:0] read_field_i,
  input  wire logic [brsb_pkg::VALUE_W-1:0]  value_i,
  output brsb_pkg::status_t                  status_o,
  output logic                               accepted_ok_o,
  output logic                               block_ready_o,
  output logic [brsb_pkg::VALUE_W-1:0]       read_value_o
);
  import brsb_pkg::*;

  logic [SAMPLE_W-1:0] sample_mem [SMP_DEPTH];
  logic [SAMPLE_W-1:0] sync_mem [ROWS];
  logic [VALUE_W-1:0]  time_mem [ROWS];

  logic [ROWS-1:0]   tvalid_q;
  logic [BLOCKS-1:0] marks_q, marks_d;
  logic [BLK_W-1:0]  fill_q, fill_d, drain_q, drain_d, fill_next;
  logic [LINE_W-1:0] line_q, line_d;

  op_e                 op_q;
  logic [RLINE_W-1:0]  rline_q;
  logic [RFIELD_W-1:0] rfield_q;
  logic [SAMPLE_W-1:0] sample_rd_q, sync_rd_q;
  logic [VALUE_W-1:0]  time_rd_q;
  logic                tvalid_rd_q;

  logic                accepted_ok_q, block_ready_q;
  logic [VALUE_W-1:0]  read_value_q, read_value_d;
  logic                overrun;

  logic [ROW_W-1:0]    wrow, rrow;
  logic [SMP_W-1:0]    waddr, raddr;
  logic [RFIELD_W-1:0] rchan_in, rchan_q;

  // write row from the fill head, read row from the drain head
  assign wrow     = ROW_W'(ROW_W'(fill_q) * ROW_W'(LINES) + ROW_W'(line_q));
  assign rrow     = ROW_W'(ROW_W'(drain_q) * ROW_W'(LINES) + ROW_W'(read_line_i));
  assign rchan_in = read_field_i - FIELD_SMP0;
  assign waddr    = SMP_W'(SMP_W'(wrow) * SMP_W'(CHANNELS) + SMP_W'(CH_W'(channel_i)));
  assign raddr    = SMP_W'(SMP_W'(rrow) * SMP_W'(CHANNELS) + SMP_W'(CH_W'(rchan_in)));

  // stores: written and read on capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      if (cmd_i.op == OP_SAMPLE && 32'(channel_i) < CHANNELS) begin
        sample_mem[waddr] <= value_i[SAMPLE_W-1:0];
      end
      if (cmd_i.op == OP_SYNC) begin
        sync_mem[wrow] <= value_i[SAMPLE_W-1:0];
      end
      if (cmd_i.op == OP_TIME) begin
        time_mem[wrow] <= value_i;
      end
      sample_rd_q <= sample_mem[raddr];
      sync_rd_q   <= sync_mem[rrow];
      time_rd_q   <= time_mem[rrow];
      tvalid_rd_q <= tvalid_q[rrow];
      op_q        <= cmd_i.op;
      rline_q     <= read_line_i;
      rfield_q    <= read_field_i;
    end
  end

  assign rchan_q   = rfield_q - FIELD_SMP0;
  assign fill_next = (fill_q == BLK_W'(BLOCKS - 1)) ? '0 : fill_q + 1'b1;

  always_comb begin
    fill_d  = fill_q;
    drain_d = drain_q;
    line_d  = line_q;
    marks_d = marks_q;
    overrun = 1'b0;
    if (cmd_i.exec) begin
      case (op_q)
        OP_ENDLINE: begin
          if (line_q == LINE_W'(LINES - 1)) begin
            line_d          = '0;
            marks_d[fill_q] = 1'b1;
            if (fill_next == drain_q) begin
              overrun = 1'b1;
            end else begin
              fill_d = fill_next;
            end
          end else begin
            line_d = line_q + 1'b1;
          end
        end
        OP_RELEASE: begin
          marks_d[drain_q] = 1'b0;
          drain_d = (drain_q == BLK_W'(BLOCKS - 1)) ? '0 : drain_q + 1'b1;
        end
        OP_CLEAR: begin
          fill_d  = '0;
          drain_d = '0;
          line_d  = '0;
          marks_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    read_value_d = '0;
    if (op_q == OP_READ && 32'(rline_q) < LINES) begin
      if (rfield_q == FIELD_TIME) begin
        read_value_d = tvalid_rd_q ? time_rd_q : '0;
      end else if (rfield_q == FIELD_SYNC) begin
        read_value_d = VALUE_W'(sync_rd_q);
      end else if (32'(rchan_q) < CHANNELS) begin
        read_value_d = VALUE_W'(sample_rd_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      drain_q  <= '0;
      line_q   <= '0;
      marks_q  <= '0;
      tvalid_q <= '0;
    end else begin
      fill_q  <= fill_d;
      drain_q <= drain_d;
      line_q  <= line_d;
      marks_q <= marks_d;
      if (cmd_i.exec && op_q == OP_CLEAR) begin
        tvalid_q <= '0;
      end else if (cmd_i.capture && cmd_i.op == OP_TIME) begin
        tvalid_q[wrow] <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      accepted_ok_q <= !overrun;
      block_ready_q <= marks_d[drain_d];
      read_value_q  <= read_value_d;
    end
  end

  assign accepted_ok_o    = accepted_ok_q;
  assign block_ready_o    = block_ready_q;
  assign read_value_o     = read_value_q;
  assign status_o.overrun = overrun;

`include "block_ring_sample_buffer_assert.svh"

  `BRSB_ASSERT_NEXT(a_release_clears, cmd_i.exec && op_q == OP_RELEASE, !marks_q[$past(drain_q)], "release left mark set")
  `BRSB_ASSERT_NOW(a_line_range, 1'b1, 32'(line_q) < LINES, "line index out of range")
  `BRSB_ASSERT_NEXT(a_overrun_holds_fill, overrun, fill_q == $past(fill_q), "fill head moved on overrun")

endmodule

`default_nettype wire

// ===== design/block_ring_sample_buffer.sv =====
// Block ring sample buffer. On capture of a request the line stores are written and read
// at the addresses set by the fill and drain heads; in the exec state that follows, the
// heads, line index and ready marks are updated and the result register is loaded. One
// request is in work at a time; the next one is taken as soon as the controller is back in
// idle and the result register is empty or its result is being taken. Clear takes effect
// at once: timestamp rows carry valid bits that are all cleared together, so there is no
// clearing pass after reset or clear.
// depends on brsb_pkg, brsb_if, brsb_ctrl and brsb_dpath
`default_nettype none

module block_ring_sample_buffer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  brsb_req_if.sink   req_i,
  brsb_rsp_if.source rsp_o
);
  import brsb_pkg::*;

  cmd_t    cmd;
  status_t status;

  brsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .kind_i      (req_i.kind),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  brsb_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .channel_i     (req_i.channel),
    .read_line_i   (req_i.read_line),
    .read_field_i  (req_i.read_field),
    .value_i       (req_i.value),
    .status_o      (status),
    .accepted_ok_o (rsp_o.accepted_ok),
    .block_ready_o (rsp_o.block_ready),
    .read_value_o  (rsp_o.read_value)
  );

endmodule

`default_nettype wire
